>>> sv/utrx_pkg.sv
package utrx_pkg;

  // Storage sizes
  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Frame format and timing
  localparam int                DATA_W    = 8;
  localparam int                CPB_W     = 16;
  localparam logic [CPB_W-1:0]  CPB_RESET = 16'd868;
  localparam logic [CPB_W-1:0]  TICK_MAX  = '1;
  localparam logic [3:0]        SLOT_START = 4'd0;
  localparam logic [3:0]        SLOT_DATA_LAST = 4'd8;
  localparam logic [3:0]        SLOT_STOP = 4'd9;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QP_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  // One classified tick from the front
  typedef struct packed {
    logic              rx_line;
    logic              rx_fall;
    logic              tx_push;
    logic [DATA_W-1:0] tx_data;
    logic              rx_pop;
  } cmd_t;

  typedef struct packed {
    logic             tx_line;
    logic             tx_accepted;
    logic [CNT_W-1:0] tx_fifo_level;
  } tx_res_t;

  typedef struct packed {
    logic              rx_valid;
    logic [DATA_W-1:0] rx_byte;
    logic [CNT_W-1:0]  rx_fifo_level;
    logic              rx_dropped;
    logic              false_start;
  } rx_res_t;

  // Advance a FIFO pointer with wrap at the depth
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

>>> sv/utrx_if.sv
interface utrx_tick_if;
  import utrx_pkg::*;
  logic              valid;
  logic              ready;
  logic              rx_line;
  logic              tx_push;
  logic [DATA_W-1:0] tx_data;
  logic              rx_pop;

  modport source (output valid, rx_line, tx_push, tx_data, rx_pop, input ready);
  modport sink   (input valid, rx_line, tx_push, tx_data, rx_pop, output ready);
endinterface

interface utrx_result_if;
  import utrx_pkg::*;
  logic              valid;
  logic              ready;
  logic              tx_line;
  logic              tx_accepted;
  logic [CNT_W-1:0]  tx_fifo_level;
  logic              rx_valid;
  logic [DATA_W-1:0] rx_byte;
  logic [CNT_W-1:0]  rx_fifo_level;
  logic              rx_dropped;
  logic              false_start;

  modport source (output valid, tx_line, tx_accepted, tx_fifo_level, rx_valid, rx_byte,
                  rx_fifo_level, rx_dropped, false_start, input ready);
  modport sink   (input valid, tx_line, tx_accepted, tx_fifo_level, rx_valid, rx_byte,
                  rx_fifo_level, rx_dropped, false_start, output ready);
endinterface

>>> sv/uart_8n1_transceiver.sv
// Channel   | Dir | Payload                                            | Request
// ----------+-----+----------------------------------------------------+------------------
// tick_in   | in  | rx_line, tx_push, tx_data, rx_pop                  | one clock tick
// res_out   | out | tx_line, tx_accepted, tx_fifo_level, rx_valid,     | one tick's result
//           |     | rx_byte, rx_fifo_level, rx_dropped, false_start    |
// cfg       | in  | cfg_we_i, cfg_wdata_i: clocks_per_bit              | register write
//
// One request per cycle sustained while the output is not stalled; a tick passes
// through the command queue, then the result register, before its result is offered.
// The transmit and receive tick engines each handle a request combinationally.
// Reset clears all control state; clocks_per_bit resets to 868. FIFO contents are not cleared.
// A stalled output holds the result register; the two-entry command queue absorbs one more
// request, then tick_in.ready drops until the result is taken.
module uart_8n1_transceiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  utrx_tick_if.sink                   tick_in,
  utrx_result_if.source               res_out,
  input  logic                        cfg_we_i,
  input  logic [utrx_pkg::CPB_W-1:0]  cfg_wdata_i
);
  import utrx_pkg::*;

  logic [CPB_W-1:0] cpb_q;

  // Front: edge detect and classification
  cmd_t fr_cmd;
  logic fr_valid, fr_ready;

  // Queue output towards the engines
  cmd_t be_cmd;
  logic be_valid, step;

  tx_res_t tx_res;
  rx_res_t rx_res;
  tx_res_t tx_res_q;
  rx_res_t rx_res_q;
  logic    res_valid_q;

  // Hold the bit period; user must send writes only while the block is idle, unenforced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpb_q <= CPB_RESET;
    end else if (cfg_we_i) begin
      cpb_q <= cfg_wdata_i;
    end
  end

  utrx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_in     (tick_in),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  utrx_cmd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_cmd_i   (fr_cmd),
    .rd_valid_o (be_valid),
    .rd_ready_i (step),
    .rd_cmd_o   (be_cmd)
  );

  // Advance the engines when a command is queued and the result register has room
  assign step = be_valid && (!res_valid_q || res_out.ready);

  utrx_tx u_tx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .push_i (be_cmd.tx_push),
    .data_i (be_cmd.tx_data),
    .cpb_i  (cpb_q),
    .res_o  (tx_res)
  );

  utrx_rx u_rx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .line_i (be_cmd.rx_line),
    .fall_i (be_cmd.rx_fall),
    .pop_i  (be_cmd.rx_pop),
    .cpb_i  (cpb_q),
    .res_o  (rx_res)
  );

  // Result register: load on step, drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      tx_res_q <= tx_res;
      rx_res_q <= rx_res;
    end
  end

  assign res_out.valid         = res_valid_q;
  assign res_out.tx_line       = tx_res_q.tx_line;
  assign res_out.tx_accepted   = tx_res_q.tx_accepted;
  assign res_out.tx_fifo_level = tx_res_q.tx_fifo_level;
  assign res_out.rx_valid      = rx_res_q.rx_valid;
  assign res_out.rx_byte       = rx_res_q.rx_byte;
  assign res_out.rx_fifo_level = rx_res_q.rx_fifo_level;
  assign res_out.rx_dropped    = rx_res_q.rx_dropped;
  assign res_out.false_start   = rx_res_q.false_start;

endmodule

>>> sv/utrx_front.sv
module utrx_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  utrx_tick_if.sink       tick_in,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output utrx_pkg::cmd_t  cmd_o
);
  import utrx_pkg::*;

  logic prev_line_q;
  logic fire;

  assign tick_in.ready = cmd_ready_i;
  assign cmd_valid_o   = tick_in.valid;
  assign fire          = tick_in.valid && cmd_ready_i;

  // Classify: falling edge of the receive line against the last accepted tick
  always_comb begin
    cmd_o.rx_line = tick_in.rx_line;
    cmd_o.rx_fall = prev_line_q && !tick_in.rx_line;
    cmd_o.tx_push = tick_in.tx_push;
    cmd_o.tx_data = tick_in.tx_data;
    cmd_o.rx_pop  = tick_in.rx_pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_line_q <= 1'b1;
    end else if (fire) begin
      prev_line_q <= tick_in.rx_line;
    end
  end

endmodule

>>> sv/utrx_cmd_queue.sv
module utrx_cmd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_valid_i,
  output logic            wr_ready_o,
  input  utrx_pkg::cmd_t  wr_cmd_i,
  output logic            rd_valid_o,
  input  logic            rd_ready_i,
  output utrx_pkg::cmd_t  rd_cmd_o
);
  import utrx_pkg::*;

  cmd_t            entry_q [Q_DEPTH];
  logic [QP_W-1:0] wptr_q, rptr_q;
  logic [QC_W-1:0] cnt_q;
  logic            wr_fire, rd_fire;

  assign wr_ready_o = (cnt_q != QC_W'(Q_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = entry_q[rptr_q];
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_fire) begin
        wptr_q <= (wptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : wptr_q + QP_W'(1);
      end
      if (rd_fire) begin
        rptr_q <= (rptr_q == QP_W'(Q_DEPTH - 1)) ? '0 : rptr_q + QP_W'(1);
      end
      cnt_q <= cnt_q + QC_W'(wr_fire) - QC_W'(rd_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      entry_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

>>> sv/utrx_tx.sv
module utrx_tx (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          push_i,
  input  logic [utrx_pkg::DATA_W-1:0]   data_i,
  input  logic [utrx_pkg::CPB_W-1:0]    cpb_i,
  output utrx_pkg::tx_res_t             res_o
);
  import utrx_pkg::*;

  logic [DATA_W-1:0] store_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_e;
  logic [DATA_W-1:0] shift_q, shift_d;
  logic [3:0]        slot_q, slot_d, slot_e, slot_m1;
  logic [CPB_W-1:0]  tc_q, tc_d, tc_e;
  logic [CPB_W:0]    tc_inc;
  logic              busy_q, busy_d;
  logic              start, accept, line;

  always_comb begin
    // Load a frame from the head when idle
    start   = !busy_q && (cnt_q != '0);
    shift_d = start ? store_q[rptr_q] : shift_q;
    busy_d  = busy_q || start;
    slot_e  = start ? SLOT_START : slot_q;
    tc_e    = start ? '0 : tc_q;
    cnt_e   = start ? (cnt_q - CNT_W'(1)) : cnt_q;
    rptr_d  = start ? ptr_next(rptr_q) : rptr_q;
    slot_m1 = slot_e - 4'd1;

    line = 1'b1;
    if (busy_d) begin
      if (slot_e == SLOT_START) begin
        line = 1'b0;
      end else if (slot_e <= SLOT_DATA_LAST) begin
        line = shift_d[slot_m1[2:0]];
      end
    end

    // Bit timing
    tc_inc = {1'b0, tc_e} + (CPB_W+1)'(1);
    slot_d = slot_e;
    tc_d   = tc_e;
    if (busy_d) begin
      if (tc_inc >= {1'b0, cpb_i}) begin
        tc_d = '0;
        if (slot_e == SLOT_STOP) begin
          busy_d = 1'b0;
          slot_d = SLOT_START;
        end else begin
          slot_d = slot_e + 4'd1;
        end
      end else begin
        tc_d = tc_inc[CPB_W-1:0];
      end
    end

    // Push after the serializer has taken its byte
    accept = push_i && (cnt_e < CNT_W'(FIFO_DEPTH));
    cnt_d  = cnt_e + CNT_W'(accept);
    wptr_d = accept ? ptr_next(wptr_q) : wptr_q;

    res_o.tx_line       = line;
    res_o.tx_accepted   = accept;
    res_o.tx_fifo_level = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q  <= '0;
      wptr_q  <= '0;
      cnt_q   <= '0;
      shift_q <= '0;
      slot_q  <= SLOT_START;
      tc_q    <= '0;
      busy_q  <= 1'b0;
    end else if (step_i) begin
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      slot_q  <= slot_d;
      tc_q    <= tc_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && accept) begin
      store_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> sv/utrx_rx.sv
module utrx_rx (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        line_i,
  input  logic                        fall_i,
  input  logic                        pop_i,
  input  logic [utrx_pkg::CPB_W-1:0]  cpb_i,
  output utrx_pkg::rx_res_t           res_o
);
  import utrx_pkg::*;

  logic [DATA_W-1:0] store_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_p;
  logic [DATA_W-1:0] shift_q, shift_d;
  logic [3:0]        slot_q, slot_d, slot_m1;
  logic [CPB_W-1:0]  tc_q, tc_d, tc_sat, half;
  logic              busy_q, busy_d;
  logic              pop_ok, push, drop, fstart;

  always_comb begin
    // Serve the pop first
    pop_ok = pop_i && (cnt_q != '0);
    cnt_p  = pop_ok ? (cnt_q - CNT_W'(1)) : cnt_q;
    rptr_d = pop_ok ? ptr_next(rptr_q) : rptr_q;

    half    = cpb_i >> 1;
    tc_sat  = (tc_q != TICK_MAX) ? (tc_q + CPB_W'(1)) : tc_q;
    slot_m1 = slot_q - 4'd1;

    busy_d  = busy_q;
    slot_d  = slot_q;
    tc_d    = tc_q;
    shift_d = shift_q;
    push    = 1'b0;
    drop    = 1'b0;
    fstart  = 1'b0;

    if (busy_q) begin
      if (slot_q == SLOT_START) begin
        // Mid start bit check
        if (tc_sat >= half) begin
          tc_d = '0;
          if (line_i) begin
            fstart = 1'b1;
            busy_d = 1'b0;
          end else begin
            slot_d = 4'd1;
          end
        end else begin
          tc_d = tc_sat;
        end
      end else if (tc_sat >= cpb_i) begin
        tc_d    = '0;
        shift_d = shift_q | (DATA_W'(line_i) << slot_m1[2:0]);
        if (slot_q == SLOT_DATA_LAST) begin
          push   = (cnt_p < CNT_W'(FIFO_DEPTH));
          busy_d = 1'b0;
          slot_d = SLOT_START;
        end else begin
          slot_d = slot_q + 4'd1;
        end
      end else begin
        tc_d = tc_sat;
      end
    end else if (fall_i) begin
      if (cnt_p >= CNT_W'(FIFO_DEPTH)) begin
        drop = 1'b1;
      end else begin
        busy_d  = 1'b1;
        slot_d  = SLOT_START;
        tc_d    = '0;
        shift_d = '0;
      end
    end

    cnt_d  = cnt_p + CNT_W'(push);
    wptr_d = push ? ptr_next(wptr_q) : wptr_q;

    res_o.rx_valid      = pop_ok;
    res_o.rx_byte       = pop_ok ? store_q[rptr_q] : '0;
    res_o.rx_fifo_level = cnt_d;
    res_o.rx_dropped    = drop;
    res_o.false_start   = fstart;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q  <= '0;
      wptr_q  <= '0;
      cnt_q   <= '0;
      shift_q <= '0;
      slot_q  <= SLOT_START;
      tc_q    <= '0;
      busy_q  <= 1'b0;
    end else if (step_i) begin
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      slot_q  <= slot_d;
      tc_q    <= tc_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && push) begin
      store_q[wptr_q] <= shift_d;
    end
  end

endmodule

>>> sv/utrx_checker.sv
module utrx_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        tx_accepted_i,
  input logic [utrx_pkg::CNT_W-1:0]  tx_fifo_level_i,
  input logic                        rx_valid_i,
  input logic [utrx_pkg::DATA_W-1:0] rx_byte_i,
  input logic [utrx_pkg::CNT_W-1:0]  rx_fifo_level_i,
  input logic                        rx_dropped_i,
  input logic                        false_start_i
);
  import utrx_pkg::*;

  // A held result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (tx_fifo_level_i <= CNT_W'(FIFO_DEPTH)) &&
                    (rx_fifo_level_i <= CNT_W'(FIFO_DEPTH)))
    else $error("fifo level beyond depth");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && tx_accepted_i |-> tx_fifo_level_i != '0)
    else $error("accepted byte not counted");

  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rx_dropped_i |-> rx_fifo_level_i == CNT_W'(FIFO_DEPTH) && !false_start_i)
    else $error("drop with room in receive fifo");

  a_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !rx_valid_i |-> rx_byte_i == '0)
    else $error("stray receive byte");

endmodule

bind uart_8n1_transceiver utrx_checker u_utrx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (res_out.valid),
  .out_ready_i     (res_out.ready),
  .tx_accepted_i   (res_out.tx_accepted),
  .tx_fifo_level_i (res_out.tx_fifo_level),
  .rx_valid_i      (res_out.rx_valid),
  .rx_byte_i       (res_out.rx_byte),
  .rx_fifo_level_i (res_out.rx_fifo_level),
  .rx_dropped_i    (res_out.rx_dropped),
  .false_start_i   (res_out.false_start)
);

>>> test/uart_8n1_transceiver_tb.sv
`timescale 1ns / 100ps

module uart_8n1_transceiver_tb;
  import utrx_pkg::*;

  localparam int RUN_LIMIT     = 500000;
  localparam int SETTLE_CYCLES = 6;

  // One tick as the stimulus queue holds it
  typedef struct packed {
    logic              rx_line;
    logic              tx_push;
    logic [DATA_W-1:0] tx_data;
    logic              rx_pop;
  } tick_item_t;

  // Both halves of one tick's outcome, in the block's own field widths
  typedef struct packed {
    tx_res_t tx;
    rx_res_t rx;
  } uart_result_t;

  logic             clk_i;
  logic             rst_ni      = 1'b1;
  logic             cfg_we_i    = 1'b0;
  logic [CPB_W-1:0] cfg_wdata_i = CPB_RESET;

  utrx_tick_if   tick ();
  utrx_result_if res ();

  uart_8n1_transceiver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_in     (tick),
    .res_out     (res),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Twin of the transceiver: bit period, transmit FIFO plus serializer,
  // receive FIFO plus deserializer. Advanced once per accepted tick.
  // ---------------------------------------------------------------------------
  logic [CPB_W-1:0]  cpb_twin = CPB_RESET;

  logic [DATA_W-1:0] txq_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  txq_rd    = '0;
  logic [CNT_W-1:0]  txq_count = '0;
  logic [DATA_W-1:0] ser_shift = '0;
  logic [3:0]        ser_slot  = SLOT_START;
  logic [CPB_W-1:0]  ser_ticks = '0;
  logic              ser_busy  = 1'b0;

  logic [DATA_W-1:0] rxq_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  rxq_rd    = '0;
  logic [CNT_W-1:0]  rxq_count = '0;
  logic [DATA_W-1:0] des_shift = '0;
  logic [3:0]        des_slot  = SLOT_START;
  logic [CPB_W-1:0]  des_ticks = '0;
  logic              des_busy  = 1'b0;
  logic              des_prev  = 1'b1;

  // Run statistics, bumped by the twin
  int unsigned frames_sent    = 0;
  int unsigned bytes_received = 0;
  int unsigned pops_served    = 0;
  int unsigned drops_seen     = 0;
  int unsigned false_starts   = 0;
  int unsigned tx_rejects     = 0;

  tick_item_t   ticks_pending[$];
  uart_result_t tick_results[$];

  int unsigned ticks_taken  = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  // Stimulus mix for the random part, in percent
  int unsigned push_pct = 0;
  int unsigned pop_pct  = 0;

  // Idle bookkeeping for both handshake sides
  int unsigned tick_calm   = 0;
  int unsigned result_calm = 0;
  logic [4:0]  tick_gap    = '0;
  logic [4:0]  result_hold = '0;

  // Advance the twin by one tick and return what the block must report for it.
  // Order within a tick: serializer start, line drive, serializer timing, push,
  // then pop, then deserializer.
  task automatic run_uart_tick(input tick_item_t t, output uart_result_t r);
    logic [CPB_W-1:0] half_bit;
    half_bit = cpb_twin >> 1;
    r = '0;
    r.tx.tx_line = 1'b1;

    // Load the serializer from the FIFO head when it is idle
    if (!ser_busy && txq_count != 0) begin
      ser_shift = txq_mem[txq_rd];
      txq_rd    = PTR_W'((int'(txq_rd) + 1) % FIFO_DEPTH);
      txq_count = txq_count - 1'b1;
      ser_busy  = 1'b1;
      ser_slot  = SLOT_START;
      ser_ticks = '0;
      frames_sent++;
    end
    if (ser_busy) begin
      if (ser_slot == SLOT_START) begin
        r.tx.tx_line = 1'b0;
      end else if (ser_slot <= SLOT_DATA_LAST) begin
        r.tx.tx_line = ser_shift[ser_slot - 4'd1];
      end else begin
        r.tx.tx_line = 1'b1;
      end
      ser_ticks = ser_ticks + 1'b1;
      // A shrunken bit period ends the current slot at once
      if (ser_ticks >= cpb_twin) begin
        ser_ticks = '0;
        ser_slot  = ser_slot + 4'd1;
        if (ser_slot > SLOT_STOP) begin
          ser_busy = 1'b0;
          ser_slot = SLOT_START;
        end
      end
    end

    // The push lands after the serializer looked, so it starts next tick
    if (t.tx_push) begin
      if (txq_count < FIFO_DEPTH) begin
        txq_mem[(int'(txq_rd) + int'(txq_count)) % FIFO_DEPTH] = t.tx_data;
        txq_count = txq_count + 1'b1;
        r.tx.tx_accepted = 1'b1;
      end else begin
        tx_rejects++;
      end
    end
    r.tx.tx_fifo_level = txq_count;

    // Serve the pop before the deserializer runs; an empty FIFO gives zeros
    if (t.rx_pop && rxq_count != 0) begin
      r.rx.rx_byte  = rxq_mem[rxq_rd];
      r.rx.rx_valid = 1'b1;
      rxq_rd        = PTR_W'((int'(rxq_rd) + 1) % FIFO_DEPTH);
      rxq_count     = rxq_count - 1'b1;
      pops_served++;
    end

    if (des_busy) begin
      if (des_ticks != TICK_MAX) begin
        des_ticks = des_ticks + 1'b1;
      end
      if (des_slot == SLOT_START) begin
        // Mid start bit: a high line here is a false start
        if (des_ticks >= half_bit) begin
          des_ticks = '0;
          if (t.rx_line) begin
            r.rx.false_start = 1'b1;
            des_busy = 1'b0;
            false_starts++;
          end else begin
            des_slot = SLOT_START + 4'd1;
          end
        end
      end else if (des_ticks >= cpb_twin) begin
        des_ticks = '0;
        des_shift = des_shift | (DATA_W'(t.rx_line) << (des_slot - 4'd1));
        des_slot  = des_slot + 4'd1;
        if (des_slot > SLOT_DATA_LAST) begin
          // Stop bit is never sampled; go idle right after the last data bit
          if (rxq_count < FIFO_DEPTH) begin
            rxq_mem[(int'(rxq_rd) + int'(rxq_count)) % FIFO_DEPTH] = des_shift;
            rxq_count = rxq_count + 1'b1;
            bytes_received++;
          end
          des_busy = 1'b0;
          des_slot = SLOT_START;
        end
      end
    end else if (des_prev && !t.rx_line) begin
      // Falling edge while idle: drop it when there is no room for the byte
      if (rxq_count >= FIFO_DEPTH) begin
        r.rx.rx_dropped = 1'b1;
        drops_seen++;
      end else begin
        des_busy  = 1'b1;
        des_slot  = SLOT_START;
        des_ticks = '0;
        des_shift = '0;
      end
    end
    des_prev = t.rx_line;
    r.rx.rx_fifo_level = rxq_count;
  endtask

  // Draw the idle cycles before the next request; now and then hold a calm
  // stretch with no idling at all.
  function automatic logic [4:0] draw_wait(inout int unsigned calm);
    logic [4:0] w;
    if (calm != 0) begin
      calm--;
      w = '0;
    end else begin
      w = 5'($urandom_range(0, 18));
      if ($urandom_range(0, 24) == 0) begin
        calm = $urandom_range(8, 48);
      end
    end
    return w;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic line, input logic push, input logic [DATA_W-1:0] data,
                          input logic pop);
    tick_item_t t;
    t.rx_line = line;
    t.tx_push = push;
    t.tx_data = data;
    t.rx_pop  = pop;
    ticks_pending.push_back(t);
  endtask

  task automatic add_tick(input logic line);
    add_item(line, $urandom_range(0, 99) < push_pct, DATA_W'($urandom),
             $urandom_range(0, 99) < pop_pct);
  endtask

  // Mostly clean 8N1 frames on the receive line at the current bit period,
  // mixed with short false starts and bursts of line noise.
  task automatic fill_random(input int n_ticks, input int unsigned cpb, input int frame_pct);
    int               start;
    int unsigned      pick;
    int unsigned      low_len;
    logic [DATA_W-1:0] b;
    start = ticks_pending.size();
    while (ticks_pending.size() - start < n_ticks) begin
      pick = $urandom_range(0, 99);
      repeat ($urandom_range(0, 2)) add_tick(1'b1);
      if (pick < frame_pct) begin
        b = DATA_W'($urandom);
        repeat (cpb) add_tick(1'b0);
        for (int i = 0; i < DATA_W; i++) begin
          repeat (cpb) add_tick(b[i]);
        end
        repeat (cpb) add_tick(1'b1);
      end else if (pick < frame_pct + (100 - frame_pct) / 2) begin
        // Go back high no later than the mid start bit check
        low_len = $urandom_range(1, ((cpb >> 1) > 1) ? (cpb >> 1) : 1);
        repeat (low_len) add_tick(1'b0);
        repeat (cpb) add_tick(1'b1);
      end else begin
        repeat ($urandom_range(1, 12)) add_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Wait until every queued tick is taken and every result has come back,
  // then let the pipeline settle.
  task automatic drain_ticks();
    do begin
      @(negedge clk_i);
    end while (ticks_pending.size() != 0 || tick.valid || tick_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the bit period; only called with the block drained
  task automatic write_cpb(input logic [CPB_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    cpb_twin     = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : run_limit
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("uart_8n1_transceiver test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tick driver: pop the next pending tick, hold it until taken, then idle for
  // the drawn gap. The twin advances at the edge where the request is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : tick_driver
    tick_item_t   nxt;
    tick_item_t   taken;
    uart_result_t r;
    if (!rst_ni) begin
      tick.valid   <= 1'b0;
      tick.rx_line <= 1'b1;
      tick.tx_push <= 1'b0;
      tick.tx_data <= '0;
      tick.rx_pop  <= 1'b0;
      tick_gap     <= '0;
    end else begin
      if (tick.valid && tick.ready) begin
        taken.rx_line = tick.rx_line;
        taken.tx_push = tick.tx_push;
        taken.tx_data = tick.tx_data;
        taken.rx_pop  = tick.rx_pop;
        run_uart_tick(taken, r);
        tick_results.push_back(r);
        ticks_taken++;
      end
      if (!tick.valid || tick.ready) begin
        if (tick_gap != 0) begin
          tick_gap   <= tick_gap - 5'd1;
          tick.valid <= 1'b0;
        end else if (ticks_pending.size() != 0) begin
          nxt = ticks_pending.pop_front();
          tick.valid   <= 1'b1;
          tick.rx_line <= nxt.rx_line;
          tick.tx_push <= nxt.tx_push;
          tick.tx_data <= nxt.tx_data;
          tick.rx_pop  <= nxt.rx_pop;
          tick_gap     <= draw_wait(tick_calm);
        end else begin
          tick.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: check each taken result against the oldest outstanding
  // tick, then stall ready for the drawn number of cycles.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    uart_result_t want;
    logic [4:0]   hold;
    if (!rst_ni) begin
      res.ready   <= 1'b0;
      result_hold <= '0;
    end else begin
      if (res.valid && res.ready) begin
        if (tick_results.size() == 0) begin
          $error("result arrived with no tick outstanding");
          mismatches++;
        end else begin
          want = tick_results.pop_front();
          compare_field("tx_line",       16'(want.tx.tx_line),       16'(res.tx_line));
          compare_field("tx_accepted",   16'(want.tx.tx_accepted),   16'(res.tx_accepted));
          compare_field("tx_fifo_level", 16'(want.tx.tx_fifo_level), 16'(res.tx_fifo_level));
          compare_field("rx_valid",      16'(want.rx.rx_valid),      16'(res.rx_valid));
          compare_field("rx_byte",       16'(want.rx.rx_byte),       16'(res.rx_byte));
          compare_field("rx_fifo_level", 16'(want.rx.rx_fifo_level), 16'(res.rx_fifo_level));
          compare_field("rx_dropped",    16'(want.rx.rx_dropped),    16'(res.rx_dropped));
          compare_field("false_start",   16'(want.rx.false_start),   16'(res.false_start));
        end
        results_seen++;
        hold = draw_wait(result_calm);
        result_hold <= hold;
        res.ready   <= (hold == 0);
      end else if (!res.ready) begin
        if (result_hold <= 5'd1) begin
          result_hold <= '0;
          res.ready   <= 1'b1;
        end else begin
          result_hold <= result_hold - 5'd1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    int unsigned bit_len;
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset bit period: pop on empty, push both byte extremes, open a frame
    add_item(1'b1, 1'b1, 8'h00, 1'b1);
    add_item(1'b1, 1'b1, 8'hFF, 1'b0);
    add_item(1'b0, 1'b0, 8'h00, 1'b0);
    add_item(1'b0, 1'b1, 8'hA5, 1'b1);
    add_item(1'b1, 1'b0, 8'h00, 1'b0);
    drain_ticks();

    // Shrink to the minimum mid-bit: the running bit ends at once, and the
    // open receive frame hits its mid start check on a high line
    write_cpb(16'd4);
    add_item(1'b1, 1'b0, 8'h00, 1'b0);
    add_item(1'b1, 1'b0, 8'h00, 1'b0);
    add_item(1'b0, 1'b0, 8'h00, 1'b0);
    add_item(1'b0, 1'b0, 8'h00, 1'b0);
    add_item(1'b0, 1'b0, 8'h00, 1'b0);
    add_item(1'b1, 1'b0, 8'h00, 1'b0);
    add_item(1'b0, 1'b1, 8'h3C, 1'b0);
    drain_ticks();

    // Widest bit period, a few pushes
    write_cpb(16'hFFFF);
    add_item(1'b1, 1'b1, 8'h5A, 1'b0);
    add_item(1'b1, 1'b1, 8'hC3, 1'b1);
    add_item(1'b0, 1'b1, 8'h81, 1'b0);
    drain_ticks();

    // Bit periods below the nominal floor: every slot lasts one tick
    write_cpb(16'd1);
    add_item(1'b0, 1'b0, 8'h00, 1'b1);
    add_item(1'b1, 1'b1, 8'h7E, 1'b0);
    add_item(1'b0, 1'b0, 8'h00, 1'b1);
    add_item(1'b0, 1'b0, 8'h00, 1'b0);
    add_item(1'b1, 1'b0, 8'h00, 1'b1);
    drain_ticks();

    write_cpb(16'd0);
    add_item(1'b1, 1'b1, 8'h81, 1'b0);
    add_item(1'b0, 1'b0, 8'h00, 1'b1);
    add_item(1'b1, 1'b1, 8'h18, 1'b0);
    add_item(1'b0, 1'b0, 8'h00, 1'b1);
    drain_ticks();

    // Back-to-back frames with no pops: fill the receive FIFO until edges are
    // dropped, and push hard enough to fill the transmit FIFO too
    write_cpb(16'd4);
    push_pct = 40;
    pop_pct  = 0;
    fill_random(800, 4, 90);
    drain_ticks();

    // Slower bit period with steady pops to drain and refill
    bit_len = $urandom_range(5, 9);
    write_cpb(CPB_W'(bit_len));
    push_pct = 15;
    pop_pct  = 40;
    fill_random(330, bit_len, 70);
    drain_ticks();

    // Minimum period again with heavy pushes and more noise
    write_cpb(16'd4);
    push_pct = 60;
    pop_pct  = 15;
    fill_random(220, 4, 60);
    drain_ticks();

    $display("Ran %0d ticks (%0d results) at bit periods 868, 4, 65535, 1, 0 and %0d.",
             ticks_taken, results_seen, bit_len);
    $display("Frames sent %0d, bytes received %0d, pops %0d, drops %0d, false starts %0d, rejects %0d.",
             frames_sent, bytes_received, pops_served, drops_seen, false_starts, tx_rejects);
    if (mismatches == 0 && tick_results.size() == 0) begin
      $display("uart_8n1_transceiver test passed");
    end else begin
      if (tick_results.size() != 0) begin
        $error("%0d ticks never produced a result", tick_results.size());
      end
      $display("uart_8n1_transceiver test failed");
    end
    $finish;
  end

endmodule
